>>> hdl/dct2d_pkg.sv
// Shared types, constants and butterfly functions for the 8x8 integer DCT.
`default_nettype none
package dct2d_pkg;

  localparam int LANES    = 8;
  localparam int SAMPLE_W = 8;
  localparam int COEF_W   = 16;
  localparam int ROW_W    = $clog2(LANES);
  localparam int NUM_BUF  = 2;
  localparam int BUF_W    = $clog2(NUM_BUF);
  localparam int ADDR_W   = BUF_W + ROW_W;
  localparam int HELD_W   = $clog2(NUM_BUF + 1);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(LANES - 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COEF_W-1:0]   coef_t;
  typedef sample_t [LANES-1:0] srow_t;
  typedef coef_t [LANES-1:0]   vec_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

  typedef struct packed {
    logic             vld;
    logic [BUF_W-1:0] idx;
  } tok_t;

  function automatic coef_t asr(coef_t x, int unsigned sh);
    return coef_t'($signed(x) >>> sh);
  endfunction

  // first half of the butterfly: returns e0..e3 in 0..3, a4..a7 in 4..7
  function automatic vec_t bf_pre(vec_t v);
    vec_t  r;
    coef_t a0, a1, a2, a3;
    a0 = v[0] + v[7];
    a1 = v[1] + v[6];
    a2 = v[2] + v[5];
    a3 = v[3] + v[4];
    r[4] = v[0] - v[7];
    r[5] = v[1] - v[6];
    r[6] = v[2] - v[5];
    r[7] = v[3] - v[4];
    r[0] = a0 + a3;
    r[1] = a1 + a2;
    r[2] = a0 - a3;
    r[3] = a1 - a2;
    return r;
  endfunction

  // second half of the butterfly, output in coefficient order
  function automatic vec_t bf_post(vec_t m);
    vec_t  r;
    coef_t c0, c1, c2, c3, c4, c5, c6, c7;
    coef_t q4, q7, o4, o5, o6, o7;
    c0 = m[0] + m[1];
    c1 = m[0] - m[1];
    c2 = m[2] + asr(m[2], 2) + asr(m[3], 1);
    c3 = asr(m[2], 1) - m[3] - asr(m[3], 2);
    q4 = asr(m[4], 2);
    q7 = asr(m[7], 2);
    o4 = q7 + m[4] + q4 - asr(m[4], 4);
    o7 = q4 - m[7] + asr(m[7], 4) - q7;
    o5 = m[5] + m[6] - asr(m[6], 2) - asr(m[6], 4);
    o6 = m[6] - m[5] + asr(m[5], 2) + asr(m[5], 4);
    c4 = o4 + o5;
    c5 = o4 - o5;
    c6 = o6 + o7;
    c7 = o6 - o7;
    r[0] = c0;
    r[1] = c4;
    r[2] = c2;
    r[3] = c5 - c7;
    r[4] = c1;
    r[5] = c5 + c7;
    r[6] = c3;
    r[7] = c6;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/dct2d_front.sv
// Input side: row transfers into a double-buffered block store, block tokens out.
`default_nettype none
module dct2d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dct2d_pkg::srow_t  in_row,
  input  logic              release_blk,
  output dct2d_pkg::tok_t   tok_push,
  input  dct2d_pkg::rd_req_t rd_req,
  output dct2d_pkg::srow_t  rd_data
);
  import dct2d_pkg::*;

  srow_t             mem [NUM_BUF*LANES];
  logic [ROW_W-1:0]  wrow_r, wrow_nxt;
  logic [BUF_W-1:0]  wbuf_r, wbuf_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic              accept;

  assign in_stall = (held_r == HELD_W'(NUM_BUF));
  assign accept   = in_valid && !in_stall;

  assign tok_push.vld = accept && (wrow_r == LAST_IDX);
  assign tok_push.idx = wbuf_r;

  always_comb begin
    wrow_nxt = wrow_r;
    wbuf_nxt = wbuf_r;
    held_nxt = held_r;
    if (accept) begin
      wrow_nxt = wrow_r + ROW_W'(1);
    end
    if (tok_push.vld) begin
      wbuf_nxt = wbuf_r + BUF_W'(1);
    end
    if (tok_push.vld && !release_blk) begin
      held_nxt = held_r + HELD_W'(1);
    end else if (!tok_push.vld && release_blk) begin
      held_nxt = held_r - HELD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrow_r <= '0;
      wbuf_r <= '0;
      held_r <= '0;
    end else begin
      wrow_r <= wrow_nxt;
      wbuf_r <= wbuf_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[{wbuf_r, wrow_r}] <= in_row;
    end
    if (rd_req.en) begin
      rd_data <= mem[rd_req.addr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/dct2d_queue.sv
// Short token queue between the input side and the transform engine.
`default_nettype none
module dct2d_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dct2d_pkg::tok_t               push,
  input  logic                          pop,
  output logic                          empty,
  output logic                          full,
  output logic [dct2d_pkg::BUF_W-1:0]   head_idx
);
  import dct2d_pkg::*;

  logic [BUF_W-1:0]  slots_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign head_idx = slots_r[rp_r];
  assign do_pop   = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.vld && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push.vld && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.vld) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      slots_r[wp_r] <= push.idx;
    end
  end

endmodule
`default_nettype wire

>>> hdl/dct2d_back.sv
// Transform engine: loads a block, column butterflies, then row butterflies out.
`default_nettype none
module dct2d_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  logic [dct2d_pkg::BUF_W-1:0]  q_idx,
  output logic                         q_pop,
  output dct2d_pkg::rd_req_t           rd_req,
  input  dct2d_pkg::srow_t             rd_data,
  output logic                         release_blk,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dct2d_pkg::vec_t              out_vec,
  output logic                         out_last
);
  import dct2d_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_DRAIN, S_COLA, S_COLB, S_ROWA, S_ROWB
  } state_t;

  state_t           state_r;
  logic [ROW_W-1:0] cnt_r;
  logic [BUF_W-1:0] buf_r;
  logic             rdv_r;
  srow_t            xrow_r [LANES];
  vec_t             mid_r  [LANES];
  vec_t             ymat_r [LANES];
  vec_t             pre_in [LANES];
  vec_t             post_out [LANES];
  logic             out_free;

  assign out_free    = !out_valid || !out_stall;
  assign q_pop       = (state_r == S_IDLE) && !q_empty;
  assign rd_req.en   = (state_r == S_LOAD);
  assign rd_req.addr = {buf_r, cnt_r};
  assign release_blk = (state_r == S_DRAIN);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int r = 0; r < LANES; r++) begin
        pre_in[l][r] = coef_t'(xrow_r[r][l]);
      end
      post_out[l] = bf_post(mid_r[l]);
    end
    if (state_r == S_ROWA) begin
      pre_in[0] = ymat_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdv_r) begin
      for (int r = 0; r < LANES - 1; r++) begin
        xrow_r[r] <= xrow_r[r+1];
      end
      xrow_r[LANES-1] <= rd_data;
    end
    if (state_r == S_COLA || state_r == S_ROWA) begin
      for (int l = 0; l < LANES; l++) begin
        mid_r[l] <= bf_pre(pre_in[l]);
      end
    end
    if (state_r == S_COLB) begin
      for (int i = 0; i < LANES; i++) begin
        for (int j = 0; j < LANES; j++) begin
          ymat_r[i][j] <= post_out[j][i];
        end
      end
    end else if (state_r == S_ROWB && out_free) begin
      for (int i = 0; i < LANES - 1; i++) begin
        ymat_r[i] <= ymat_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      buf_r     <= '0;
      rdv_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rdv_r <= (state_r == S_LOAD);
      if (out_valid && !out_stall && state_r != S_ROWB) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            buf_r   <= q_idx;
            cnt_r   <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt_r <= cnt_r + ROW_W'(1);
          if (cnt_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: state_r <= S_COLA;
        S_COLA:  state_r <= S_COLB;
        S_COLB:  state_r <= S_ROWA;
        S_ROWA:  state_r <= S_ROWB;
        S_ROWB: begin
          if (out_free) begin
            out_vec   <= post_out[0];
            out_last  <= (cnt_r == LAST_IDX);
            out_valid <= 1'b1;
            cnt_r     <= cnt_r + ROW_W'(1);
            state_r   <= (cnt_r == LAST_IDX) ? S_IDLE : S_ROWA;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/integer_dct_8x8_2d.sv
// Throughput: rows enter one per cycle while in_stall is low; per block the engine
// dispatches a token, makes eight store reads, runs the column pass, then the row pass
// for each output row; a second block buffer lets input overlap the engine.
// Reset: synchronous active-low rst_n clears row count, buffer index and occupancy,
// queue pointers and count, and engine state.
`default_nettype none
module integer_dct_8x8_2d (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dct2d_pkg::SAMPLE_W-1:0]      in_sample_0,
  input  logic [dct2d_pkg::SAMPLE_W-1:0]      in_sample_1,
  input  logic [dct2d_pkg::SAMPLE_W-1:0]      in_sample_2,
  input  logic [dct2d_pkg::SAMPLE_W-1:0]      in_sample_3,
  input  logic [dct2d_pkg::SAMPLE_W-1:0]      in_sample_4,
  input  logic [dct2d_pkg::SAMPLE_W-1:0]      in_sample_5,
  input  logic [dct2d_pkg::SAMPLE_W-1:0]      in_sample_6,
  input  logic [dct2d_pkg::SAMPLE_W-1:0]      in_sample_7,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dct2d_pkg::COEF_W-1:0] out_coef_0,
  output logic signed [dct2d_pkg::COEF_W-1:0] out_coef_1,
  output logic signed [dct2d_pkg::COEF_W-1:0] out_coef_2,
  output logic signed [dct2d_pkg::COEF_W-1:0] out_coef_3,
  output logic signed [dct2d_pkg::COEF_W-1:0] out_coef_4,
  output logic signed [dct2d_pkg::COEF_W-1:0] out_coef_5,
  output logic signed [dct2d_pkg::COEF_W-1:0] out_coef_6,
  output logic signed [dct2d_pkg::COEF_W-1:0] out_coef_7,
  output logic                                out_last_row
);
  import dct2d_pkg::*;

  srow_t            in_row;
  srow_t            rd_data;
  rd_req_t          rd_req;
  tok_t             tok_push;
  logic             release_blk;
  logic             q_pop;
  logic             q_empty;
  logic             q_full;
  logic [BUF_W-1:0] q_idx;
  vec_t             out_vec;

  assign in_row[0] = in_sample_0;
  assign in_row[1] = in_sample_1;
  assign in_row[2] = in_sample_2;
  assign in_row[3] = in_sample_3;
  assign in_row[4] = in_sample_4;
  assign in_row[5] = in_sample_5;
  assign in_row[6] = in_sample_6;
  assign in_row[7] = in_sample_7;

  assign out_coef_0 = out_vec[0];
  assign out_coef_1 = out_vec[1];
  assign out_coef_2 = out_vec[2];
  assign out_coef_3 = out_vec[3];
  assign out_coef_4 = out_vec[4];
  assign out_coef_5 = out_vec[5];
  assign out_coef_6 = out_vec[6];
  assign out_coef_7 = out_vec[7];

  dct2d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_row      (in_row),
    .release_blk (release_blk),
    .tok_push    (tok_push),
    .rd_req      (rd_req),
    .rd_data     (rd_data)
  );

  dct2d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (tok_push),
    .pop      (q_pop),
    .empty    (q_empty),
    .full     (q_full),
    .head_idx (q_idx)
  );

  dct2d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_idx       (q_idx),
    .q_pop       (q_pop),
    .rd_req      (rd_req),
    .rd_data     (rd_data),
    .release_blk (release_blk),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_vec     (out_vec),
    .out_last    (out_last_row)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    tok_push.vld |-> !q_full)
    else $error("block token pushed into full queue");

  a_release_frees: assert property (@(posedge clk) disable iff (!rst_n)
    release_blk |=> !in_stall)
    else $error("input stalled after a block buffer was released");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row && !out_stall |=> !out_valid)
    else $error("coefficient row right after the last row of a block");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the 8x8 integer DCT: row stimulus, coefficient prediction, checks.
`default_nettype none
module tb_top;
  import dct2d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    vec_t coef;
    logic last_row;
  } coef_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  srow_t in_row = '0;
  wire in_stall;
  wire out_valid;
  wire out_last_row;
  wire [COEF_W-1:0] out_coef [LANES];

  srow_t pixel_row_q[$];
  coef_row_t coef_row_q[$];
  sample_t model_block [LANES][LANES];
  logic [ROW_W-1:0] model_row = '0;
  int rows_accepted = 0;
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_stall_pct;

  integer_dct_8x8_2d dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_0  (in_row[0]),
    .in_sample_1  (in_row[1]),
    .in_sample_2  (in_row[2]),
    .in_sample_3  (in_row[3]),
    .in_sample_4  (in_row[4]),
    .in_sample_5  (in_row[5]),
    .in_sample_6  (in_row[6]),
    .in_sample_7  (in_row[7]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_coef_0   (out_coef[0]),
    .out_coef_1   (out_coef[1]),
    .out_coef_2   (out_coef[2]),
    .out_coef_3   (out_coef[3]),
    .out_coef_4   (out_coef[4]),
    .out_coef_5   (out_coef[5]),
    .out_coef_6   (out_coef[6]),
    .out_coef_7   (out_coef[7]),
    .out_last_row (out_last_row)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic coef_t shift_right_arith(coef_t x, int unsigned n);
    coef_t r;
    r = $signed(x) >>> n;
    return r;
  endfunction

  function automatic vec_t dct_butterfly(vec_t x);
    vec_t y;
    coef_t s0, s1, s2, s3, d0, d1, d2, d3;
    coef_t e0, e1, e2, e3, k0, k1, k2, k3;
    coef_t q0, q3, p0, p1, p2, p3;
    s0 = x[0] + x[7];
    s1 = x[1] + x[6];
    s2 = x[2] + x[5];
    s3 = x[3] + x[4];
    d0 = x[0] - x[7];
    d1 = x[1] - x[6];
    d2 = x[2] - x[5];
    d3 = x[3] - x[4];
    e0 = s0 + s3;
    e1 = s1 + s2;
    e2 = s0 - s3;
    e3 = s1 - s2;
    q0 = shift_right_arith(d0, 2);
    q3 = shift_right_arith(d3, 2);
    p0 = q3 + d0 + q0 - shift_right_arith(d0, 4);
    p3 = q0 - d3 + shift_right_arith(d3, 4) - q3;
    p1 = d1 + d2 - shift_right_arith(d2, 2) - shift_right_arith(d2, 4);
    p2 = d2 - d1 + shift_right_arith(d1, 2) + shift_right_arith(d1, 4);
    k0 = p0 + p1;
    k1 = p0 - p1;
    k2 = p2 + p3;
    k3 = p2 - p3;
    y[0] = e0 + e1;
    y[1] = k0;
    y[2] = e2 + shift_right_arith(e2, 2) + shift_right_arith(e3, 1);
    y[3] = k1 - k3;
    y[4] = e0 - e1;
    y[5] = k1 + k3;
    y[6] = shift_right_arith(e2, 1) - e3 - shift_right_arith(e3, 2);
    y[7] = k2;
    return y;
  endfunction

  // butterfly down each lane then transpose, twice; queue the eight coefficient rows
  task automatic transform_block();
    coef_t m [LANES][LANES];
    coef_t t [LANES][LANES];
    vec_t lane_vec;
    coef_row_t res;
    for (int r = 0; r < LANES; r++)
      for (int l = 0; l < LANES; l++)
        m[r][l] = coef_t'(model_block[r][l]);
    for (int p = 0; p < 2; p++) begin
      for (int l = 0; l < LANES; l++) begin
        for (int r = 0; r < LANES; r++) lane_vec[r] = m[r][l];
        lane_vec = dct_butterfly(lane_vec);
        for (int r = 0; r < LANES; r++) t[l][r] = lane_vec[r];
      end
      m = t;
    end
    for (int r = 0; r < LANES; r++) begin
      for (int l = 0; l < LANES; l++) res.coef[l] = m[r][l];
      res.last_row = (r == LANES - 1);
      coef_row_q.push_back(res);
    end
  endtask

  task automatic store_pixel_row(srow_t row);
    for (int l = 0; l < LANES; l++) model_block[model_row][l] = row[l];
    if (model_row == LAST_IDX) transform_block();
    model_row = model_row + 1'b1;
  endtask

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic check_coef_row();
    coef_row_t exp_row;
    if (coef_row_q.size() == 0) begin
      flag_error($sformatf("unexpected coefficient row, last_row=%0b", out_last_row));
    end else begin
      exp_row = coef_row_q.pop_front();
      for (int l = 0; l < LANES; l++)
        if (out_coef[l] !== exp_row.coef[l])
          flag_error($sformatf("coef lane %0d: expected %0d, got %0d", l,
                               $signed(exp_row.coef[l]), $signed(out_coef[l])));
      if (out_last_row !== exp_row.last_row)
        flag_error($sformatf("last_row: expected %0b, got %0b",
                             exp_row.last_row, out_last_row));
    end
  endtask

  always_comb begin
    if (rows_accepted < 40) begin
      send_idle_pct = 20;
      recv_stall_pct = 88;
    end else if (rows_accepted < 80) begin
      send_idle_pct = 88;
      recv_stall_pct = 20;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  end

  // driver
  always @(posedge clk) begin
    logic take;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        store_pixel_row(in_row);
        rows_accepted++;
      end
      if (!in_valid || take) begin
        if (pixel_row_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_row <= pixel_row_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_coef_row();
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("integer_dct_8x8_2d regression: fail");
      $finish;
    end
  end

  initial begin
    srow_t row;
    int total_rows;
    int style;
    int level;
    // flat black, flat white, full-swing checkerboard
    for (int b = 0; b < 3; b++)
      for (int r = 0; r < LANES; r++) begin
        for (int l = 0; l < LANES; l++)
          case (b)
            0: row[l] = 8'd0;
            1: row[l] = 8'd255;
            default: row[l] = ((r + l) % 2) ? 8'd255 : 8'd0;
          endcase
        pixel_row_q.push_back(row);
      end
    for (int b = 0; b < 11; b++) begin
      style = $urandom_range(3);
      level = $urandom_range(255);
      for (int r = 0; r < LANES; r++) begin
        for (int l = 0; l < LANES; l++)
          case (style)
            2: row[l] = $urandom_range(1) ? 8'd255 : 8'd0;
            3: row[l] = sample_t'(level + $urandom_range(16) - 8);
            default: row[l] = sample_t'($urandom_range(255));
          endcase
        pixel_row_q.push_back(row);
      end
    end
    total_rows = pixel_row_q.size();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (rows_accepted < total_rows || coef_row_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (coef_row_q.size() != 0)
      flag_error($sformatf("%0d coefficient rows never arrived", coef_row_q.size()));
    if (errors == 0) begin
      $display("integer_dct_8x8_2d regression: pass");
    end else begin
      $display("integer_dct_8x8_2d regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hdl/dct2d_pkg.sv
hdl/dct2d_front.sv
hdl/dct2d_queue.sv
hdl/dct2d_back.sv
hdl/integer_dct_8x8_2d.sv
tb/sv/tb_top.sv
